/* rtl/nfcm_pkg.sv */
// ---------------------------------------------------------------------------
// nfcm_pkg: shared types and constants of the NFC-A card frame modulator
// Holds the bit-pattern constants and the job word passed from the front
// part through the queue to the serializer.
// ---------------------------------------------------------------------------
package nfcm_pkg;

  // Modulation levels of one bit, bit 15 goes out first.
  localparam logic [15:0] PATTERN_ONE  = 16'hAA00;
  localparam logic [15:0] PATTERN_ZERO = 16'h00AA;

  // A job holds at most the start symbol, eight data bits and parity.
  localparam int unsigned MAX_BITS  = 10;
  localparam int unsigned CNT_W     = 4;
  localparam logic [3:0]  FULL_BYTE = 4'd8;

  typedef struct packed {
    logic [MAX_BITS-1:0] bits;   // bit 0 is sent first
    logic [CNT_W-1:0]    count;  // number of valid bits, 1 to 10
  } job_t;

endpackage

/* rtl/nfcm_intf.sv */
// ---------------------------------------------------------------------------
// nfcm_intf: valid/ready channels of the NFC-A card frame modulator
// The input channel carries one byte with its framing; the output channel
// carries one 16-slot modulation pattern per word.
// ---------------------------------------------------------------------------
interface nfcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       parity_bit;
  logic [3:0] bit_count;
  logic       frame_start;

  modport source (output valid, data_byte, parity_bit, bit_count, frame_start,
                  input ready);
  modport sink   (input valid, data_byte, parity_bit, bit_count, frame_start,
                  output ready);
endinterface

interface nfcm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] slot_pattern;
  logic        last_of_item;

  modport source (output valid, slot_pattern, last_of_item, input ready);
  modport sink   (input valid, slot_pattern, last_of_item, output ready);
endinterface

/* rtl/nfcm_front.sv */
// ---------------------------------------------------------------------------
// nfcm_front: input classifier
// Turns one input word into the ordered list of bits to send and its length.
// ---------------------------------------------------------------------------
module nfcm_front (
  nfcm_in_if.sink         in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output nfcm_pkg::job_t  push_job_o
);

  logic [3:0] cnt_sat;
  logic       full;
  logic [8:0] data_ext;
  logic [3:0] n_data;

  always_comb begin
    cnt_sat  = (in_i.bit_count > nfcm_pkg::FULL_BYTE) ? nfcm_pkg::FULL_BYTE
                                                      : in_i.bit_count;
    full     = (cnt_sat == nfcm_pkg::FULL_BYTE);
    // Parity rides behind the byte only on a full byte.
    data_ext = {in_i.parity_bit & full, in_i.data_byte};
    n_data   = full ? (cnt_sat + 4'd1) : cnt_sat;

    if (in_i.frame_start) begin
      push_job_o.bits = {data_ext, 1'b1};
    end else begin
      push_job_o.bits = {1'b0, data_ext};
    end
    push_job_o.count = n_data + {3'b000, in_i.frame_start};
  end

  // A word with nothing to send is accepted and dropped.
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid && (push_job_o.count != 4'd0);

endmodule

/* rtl/nfcm_queue.sv */
// ---------------------------------------------------------------------------
// nfcm_queue: two-entry job queue
// Decouples the classifier from the serializer so each side stalls alone.
// ---------------------------------------------------------------------------
module nfcm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  nfcm_pkg::job_t  push_job_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output nfcm_pkg::job_t  pop_job_o,
  output logic [1:0]      level_o
);

  nfcm_pkg::job_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     level_q, level_d;
  logic           push, pop;

  assign push_ready_o = (level_q != 2'd2);
  assign pop_valid_o  = (level_q != 2'd0);
  assign pop_job_o    = entry_q[rd_ptr_q];
  assign level_o      = level_q;

  always_comb begin
    push     = push_valid_i && push_ready_o;
    pop      = pop_valid_o && pop_ready_i;
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    level_d  = level_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      level_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

/* rtl/nfcm_back.sv */
// ---------------------------------------------------------------------------
// nfcm_back: bit serializer
// Emits one modulation pattern per cycle, unless the output stalls, from the
// current job into an output register, loading the next job without a gap.
// ---------------------------------------------------------------------------
module nfcm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  nfcm_pkg::job_t  job_i,
  nfcm_out_if.source      out_o
);

  logic                          busy_q, busy_d;
  logic [nfcm_pkg::MAX_BITS-1:0] shift_q, shift_d;
  logic [nfcm_pkg::CNT_W-1:0]    remain_q, remain_d;
  logic                          valid_q, valid_d;
  logic [15:0]                   pattern_q, pattern_d;
  logic                          last_q, last_d;
  logic                          advance;
  logic                          cur_bit;
  logic                          cur_last;

  assign advance     = !valid_q || out_o.ready;
  assign pop_ready_o = advance && !busy_q;

  always_comb begin
    busy_d    = busy_q;
    shift_d   = shift_q;
    remain_d  = remain_q;
    valid_d   = valid_q;
    pattern_d = pattern_q;
    last_d    = last_q;
    cur_bit   = busy_q ? shift_q[0] : job_i.bits[0];
    cur_last  = busy_q ? (remain_q == 4'd1) : (job_i.count == 4'd1);

    if (advance) begin
      valid_d = busy_q || pop_valid_i;
      if (busy_q) begin
        shift_d  = shift_q >> 1;
        remain_d = remain_q - 4'd1;
        busy_d   = !cur_last;
      end else if (pop_valid_i) begin
        shift_d  = job_i.bits >> 1;
        remain_d = job_i.count - 4'd1;
        busy_d   = !cur_last;
      end
      pattern_d = cur_bit ? nfcm_pkg::PATTERN_ONE : nfcm_pkg::PATTERN_ZERO;
      last_d    = cur_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q   <= shift_d;
    remain_q  <= remain_d;
    pattern_q <= pattern_d;
    last_q    <= last_d;
  end

  assign out_o.valid        = valid_q;
  assign out_o.slot_pattern = pattern_q;
  assign out_o.last_of_item = last_q;

endmodule

/* rtl/nfcm_card_frame_modulator.sv */
// ---------------------------------------------------------------------------
// nfca_card_frame_modulator: NFC-A card load-modulation encoder
// Expands each byte word into Manchester-coded subcarrier patterns.
// ---------------------------------------------------------------------------
// Usage. The input channel takes one word per byte: the byte, its parity,
// a bit count and a frame-start flag. The output channel gives one 16-slot
// modulation pattern per bit, bit 15 first, with last_of_item marking the
// final pattern of each input word. A frame start adds a leading one (the
// start-of-frame symbol), bits go least significant first, and a full byte
// (count 8 or more) is followed by its parity bit, so one word yields up to
// ten patterns. A word with a zero count and no frame start yields nothing.
// The first pattern passes through the job queue and then the pattern
// register after its input word is taken. The serializer sends one
// pattern per cycle while the output channel accepts and loads the
// next job with no gap, so a steady stream of full bytes with frame start
// runs at one word per ten patterns; the output channel sets that pace.
// A two-entry job queue sits between the classifier and the serializer;
// when the receiver stalls, the pattern register holds and the input keeps
// accepting words until the queue is full. Reset empties the queue and the
// output register; no clearing pass is needed.
// ---------------------------------------------------------------------------
module nfca_card_frame_modulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  nfcm_in_if.sink     in_i,
  nfcm_out_if.source  out_o
);

  logic           push_valid;
  logic           push_ready;
  nfcm_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  nfcm_pkg::job_t pop_job;
  logic [1:0]     queue_level;

  // Classifier: works out the bit list of each word.
  nfcm_front u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  // Job queue between the two halves.
  nfcm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job),
    .level_o      (queue_level)
  );

  // Serializer with the registered output word.
  nfcm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_o       (out_o)
  );

`ifndef ASSERT_OFF
  // The queue never holds more than its two entries.
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_level != 2'd3)
    else $error("job queue level out of range");

  // Every queued job has between one and ten bits.
  a_job_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid && push_ready) |->
      (push_job.count != 4'd0 && push_job.count <= 4'd10))
    else $error("job with bad bit count queued");

  // A word with nothing to send never reaches the queue.
  a_empty_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.bit_count == 4'd0 && !in_i.frame_start) |-> !push_valid)
    else $error("empty word queued");

  // A job is only taken from a queue that holds one.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ready && pop_valid |-> queue_level != 2'd0)
    else $error("pop from empty job queue");
`endif

endmodule

/* verif/nfca_frame_checker.sv */
// ---------------------------------------------------------------------------
// nfca_frame_checker: pattern predictor and scoreboard for the modulator
// Watches both channels, expands each accepted byte word into the expected
// modulation patterns and compares every accepted pattern word in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module nfca_frame_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nfcm_in_if   byte_mon_i,
  nfcm_out_if  pattern_mon_i,
  input  logic flush_i,
  output int   errors_o,
  output int   pending_o
);

  // Manchester levels on the subcarrier: a one modulates the first half.
  localparam logic [15:0] MOD_ONE    = 16'hAA00;
  localparam logic [15:0] MOD_ZERO   = 16'h00AA;
  localparam logic [3:0]  FULL_COUNT = 4'd8;

  typedef struct packed {
    logic [15:0] pattern;
    logic        last;
  } slot_word_t;

  slot_word_t upcoming_q[$];
  int         mismatches = 0;
  bit         flushed    = 1'b0;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Start symbol, data bits LSB first, then parity for a full byte.
  // Counts above eight act as a full byte.
  function automatic void expand_byte(input logic [7:0] data, input logic par,
                                      input logic [3:0] cnt, input logic sof);
    logic [15:0] seq[$];
    slot_word_t  w;
    logic [3:0]  used;
    used = (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
    if (sof) seq.push_back(MOD_ONE);
    for (int i = 0; i < int'(used); i++) seq.push_back(data[i] ? MOD_ONE : MOD_ZERO);
    if (used == FULL_COUNT) seq.push_back(par ? MOD_ONE : MOD_ZERO);
    foreach (seq[i]) begin
      w.pattern = seq[i];
      w.last    = (i == seq.size() - 1);
      upcoming_q.push_back(w);
    end
  endfunction

  // Output is handled before input: a byte taken at this edge cannot have
  // produced a pattern at the same edge.
  always @(posedge clk_i) begin
    slot_word_t want;
    if (rst_ni) begin
      if (pattern_mon_i.valid && pattern_mon_i.ready) begin
        if (upcoming_q.size() == 0) begin
          report_mismatch($sformatf("pattern %h last %b arrived with none expected",
                                    pattern_mon_i.slot_pattern,
                                    pattern_mon_i.last_of_item));
        end else begin
          want = upcoming_q.pop_front();
          if (pattern_mon_i.slot_pattern !== want.pattern)
            report_mismatch($sformatf("slot_pattern is %h, expected %h",
                                      pattern_mon_i.slot_pattern, want.pattern));
          if (pattern_mon_i.last_of_item !== want.last)
            report_mismatch($sformatf("last_of_item is %b, expected %b on pattern %h",
                                      pattern_mon_i.last_of_item, want.last,
                                      want.pattern));
        end
      end
      if (byte_mon_i.valid && byte_mon_i.ready)
        expand_byte(byte_mon_i.data_byte, byte_mon_i.parity_bit,
                    byte_mon_i.bit_count, byte_mon_i.frame_start);
      if (flush_i && !flushed) begin
        flushed = 1'b1;
        while (upcoming_q.size() > 0) begin
          want = upcoming_q.pop_front();
          report_mismatch($sformatf("pattern %h last %b never arrived",
                                    want.pattern, want.last));
        end
      end
      pending_o <= upcoming_q.size();
    end
  end

endmodule

/* verif/nfca_card_frame_modulator_test.sv */
// ---------------------------------------------------------------------------
// nfca_card_frame_modulator_test: top-level test of the card frame modulator
// Drives byte words with directed corner cases and random frames, stalls the
// pattern channel at random, and lets the checker score every pattern word.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module nfca_card_frame_modulator_test;

  // A full byte is the common case on the air; counts are four bits wide.
  localparam logic [3:0] FULL_COUNT  = 4'd8;
  // Long receiver stall, well beyond what the two-entry job queue absorbs.
  localparam int         HOLD_CYCLES = 90;
  // Cycles without any accepted word before the run is declared hung.
  localparam int         QUIET_LIMIT = 1000;
  // The first pattern passes through the job queue and the pattern register
  // after its word is taken; DRAIN_CYCLES more allow for straggling words.
  localparam int         DRAIN_CYCLES = 8;

  logic clk_i;
  logic rst_ni;
  logic flush_q;
  int   fail_count;
  int   pending;
  int   quiet;

  // Control shared between the sender and the receiver processes.
  bit   idle_on;
  bit   hold_req;

  nfcm_in_if  byte_ch ();
  nfcm_out_if pattern_ch ();

  nfca_card_frame_modulator u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (pattern_ch)
  );

  nfca_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_mon_i    (byte_ch),
    .pattern_mon_i (pattern_ch),
    .flush_i       (flush_q),
    .errors_o      (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hang detection: any cycle that moves a word on either channel resets the
  // count, so long but legitimate stalls never trip it.
  always @(posedge clk_i) begin
    if (!rst_ni || (byte_ch.valid && byte_ch.ready) ||
        (pattern_ch.valid && pattern_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver side. Ready alternates between open stretches and stall bursts
  // while idling is on. A hold request from the sender closes the channel
  // for a long stretch so that the job queue fills and the input stalls.
  initial begin
    int unsigned span;
    pattern_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pattern_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(3) == 0) begin
        pattern_ch.ready <= 1'b0;
        span = $urandom_range(13, 1);
        repeat (span - 1) @(negedge clk_i);
      end else begin
        pattern_ch.ready <= 1'b1;
        span = $urandom_range(20, 1);
        repeat (span - 1) @(negedge clk_i);
      end
    end
  end

  // Offers one byte word at a falling edge and returns at the falling edge
  // after it was taken. Valid is left high so back-to-back words need no
  // second assignment in the same step.
  task automatic send_word(input logic [7:0] data, input logic par,
                           input logic [3:0] cnt, input logic sof);
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= data;
    byte_ch.parity_bit  <= par;
    byte_ch.bit_count   <= cnt;
    byte_ch.frame_start <= sof;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Random sender gap, taken only while idling is on; the payload is scrambled
  // meanwhile so that nothing leaks from a word that is not valid.
  task automatic sender_gap();
    int unsigned span;
    if (idle_on && $urandom_range(3) == 0) begin
      span = $urandom_range(13, 1);
      byte_ch.valid       <= 1'b0;
      byte_ch.data_byte   <= 8'($urandom);
      byte_ch.parity_bit  <= 1'($urandom);
      byte_ch.bit_count   <= 4'($urandom);
      byte_ch.frame_start <= 1'($urandom);
      repeat (span) @(negedge clk_i);
    end
  endtask

  // Mostly well-formed frames: a first byte with the start symbol followed
  // by full bytes, or a short frame of one to seven bits. The rest is noise
  // with every field value allowed, including zero and oversized counts.
  task automatic random_traffic(input int unsigned words);
    int unsigned left;
    int unsigned pick;
    int unsigned body;
    left = words;
    while (left > 0) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        body = $urandom_range(6);
        for (int unsigned i = 0; i <= body && left > 0; i++) begin
          sender_gap();
          send_word(8'($urandom), 1'($urandom), FULL_COUNT, i == 0);
          left--;
        end
      end else if (pick < 8) begin
        sender_gap();
        send_word(8'($urandom), 1'($urandom), 4'($urandom_range(7, 1)), 1'b1);
        left--;
      end else begin
        sender_gap();
        send_word(8'($urandom), 1'($urandom), 4'($urandom_range(15)), 1'($urandom));
        left--;
      end
    end
  endtask

  // Waits with the input idle until the checker holds no expectation.
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni              = 1'b0;
    flush_q             = 1'b0;
    idle_on             = 1'b1;
    hold_req            = 1'b0;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = 8'h00;
    byte_ch.parity_bit  = 1'b0;
    byte_ch.bit_count   = 4'd0;
    byte_ch.frame_start = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words. Field extremes first: all-zero and all-one bytes with
    // both parity values, with and without the start symbol.
    send_word(8'h00, 1'b0, FULL_COUNT, 1'b1);
    send_word(8'hFF, 1'b1, FULL_COUNT, 1'b0);
    send_word(8'hFF, 1'b0, FULL_COUNT, 1'b1);
    send_word(8'h00, 1'b1, FULL_COUNT, 1'b0);
    send_word(8'hA5, 1'b0, FULL_COUNT, 1'b1);
    send_word(8'h5A, 1'b1, FULL_COUNT, 1'b0);
    // Short frames carry no parity, so the parity bit must be ignored.
    send_word(8'h26, 1'b1, 4'd7, 1'b1);
    send_word(8'h52, 1'b0, 4'd7, 1'b1);
    send_word(8'h01, 1'b1, 4'd1, 1'b1);
    send_word(8'hFE, 1'b1, 4'd1, 1'b0);
    send_word(8'h7F, 1'b1, 4'd4, 1'b0);
    send_word(8'h80, 1'b0, 4'd6, 1'b1);
    // A zero count sends only the start symbol when one is asked for, and
    // nothing at all otherwise.
    send_word(8'hFF, 1'b1, 4'd0, 1'b1);
    send_word(8'hFF, 1'b1, 4'd0, 1'b0);
    send_word(8'h00, 1'b0, 4'd0, 1'b0);
    send_word(8'h3C, 1'b0, 4'd0, 1'b1);
    // Counts above eight behave as a full byte with parity.
    send_word(8'h3C, 1'b1, 4'd9, 1'b0);
    send_word(8'hC3, 1'b0, 4'd15, 1'b1);
    send_word(8'h81, 1'b1, 4'd12, 1'b0);
    send_word(8'h69, 1'b0, 4'd10, 1'b1);
    wait_drained();

    // Random traffic with idling on both sides.
    random_traffic(120);

    // Close the receiver for a long stretch while full bytes keep coming;
    // the queue fills and the input has to back-pressure.
    hold_req = 1'b1;
    for (int i = 0; i < 14; i++)
      send_word(8'($urandom), 1'($urandom), FULL_COUNT, 1'b1);

    // Pause the sender until every expected pattern has arrived.
    wait_drained();

    random_traffic(120);

    // Final stretch at full rate with no idling on either side.
    idle_on = 1'b0;
    random_traffic(60);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    flush_q <= 1'b1;
    @(posedge clk_i);
    @(negedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
